FILE: hdl/ppu_vsa_pkg.sv
// ============================================================================
// ppu_vsa_pkg
// Shared types and constants of the VRAM and scroll-address unit.
// ============================================================================
package ppu_vsa_pkg;

  // Width of a mirrored video memory address (16 KiB space).
  localparam int unsigned VRAM_AW = 14;

  // Operation codes carried in the func field.
  localparam logic [3:0] FUNC_CTRL         = 4'd0;
  localparam logic [3:0] FUNC_SCROLL       = 4'd1;
  localparam logic [3:0] FUNC_ADDR         = 4'd2;
  localparam logic [3:0] FUNC_DATA_WRITE   = 4'd3;
  localparam logic [3:0] FUNC_DATA_READ    = 4'd4;
  localparam logic [3:0] FUNC_INCREMENT    = 4'd5;
  localparam logic [3:0] FUNC_CLEAR_TOGGLE = 4'd6;
  localparam logic [3:0] FUNC_INC_X        = 4'd7;
  localparam logic [3:0] FUNC_INC_Y        = 4'd8;
  localparam logic [3:0] FUNC_COPY_X       = 4'd9;
  localparam logic [3:0] FUNC_COPY_Y       = 4'd10;
  localparam logic [3:0] FUNC_DIRECT_READ  = 4'd11;
  localparam logic [3:0] FUNC_DIRECT_WRITE = 4'd12;

  // Nametable mirroring modes.
  localparam logic [2:0] MIRROR_HORIZONTAL  = 3'd0;
  localparam logic [2:0] MIRROR_VERTICAL    = 3'd1;
  localparam logic [2:0] MIRROR_SINGLE_LOW  = 3'd2;
  localparam logic [2:0] MIRROR_SINGLE_HIGH = 3'd3;

  // Coarse Y values with special wrap behavior.
  localparam logic [4:0] COARSE_Y_LAST_ROW = 5'd29;
  localparam logic [4:0] COARSE_Y_MAX      = 5'd31;

  // One input transaction.
  typedef struct packed {
    logic [3:0]  func;
    logic [7:0]  value;
    logic [15:0] address;
    logic        increment_by_32;
  } in_item_t;

  // Scroll and address register state.
  typedef struct packed {
    logic [14:0] cur;
    logic [14:0] tmp;
    logic [2:0]  fine_x;
    logic        toggle;
  } scroll_state_t;

  // Source of the read data of a result.
  typedef enum logic [1:0] {
    RD_NONE,
    RD_MEM,
    RD_BUF
  } rd_sel_t;

endpackage

FILE: hdl/ppu_vsa_if.sv
// ============================================================================
// ppu_vsa_if
// Valid/ready channel interfaces for input and result transactions.
// ============================================================================
interface ppu_vsa_in_if;
  logic        valid;
  logic        ready;
  logic [3:0]  func;
  logic [7:0]  value;
  logic [15:0] address;
  logic        increment_by_32;

  modport source (output valid, func, value, address, increment_by_32, input ready);
  modport sink (input valid, func, value, address, increment_by_32, output ready);
endinterface

interface ppu_vsa_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  read_data;
  logic [14:0] current_address;
  logic [14:0] temp_address;
  logic [2:0]  fine_x;
  logic        toggle;

  modport source (output valid, read_data, current_address, temp_address, fine_x, toggle,
                  input ready);
  modport sink (input valid, read_data, current_address, temp_address, fine_x, toggle,
                output ready);
endinterface

FILE: hdl/ppu_vram_scroll_address_unit.sv
// ============================================================================
// ppu_vram_scroll_address_unit
// VRAM and scroll-address unit: address registers, mirroring and video memory.
// ============================================================================
//
//   Port group   Direction  Handshake     Contents
//   in_ch        sink       valid/ready   func, value, address, increment_by_32
//   out_ch       source     valid/ready   read_data, addresses, fine_x, toggle
//   cfg_*        sink       write enable  mirror_mode (3 bits)
//
// One transaction is accepted per cycle when the output is drained; a result
// passes the input register, the memory read register and the result register
// before it is presented. The memory read register is there because the
// memory read port is registered.
// Reset clears the address registers, fine X, toggle, read buffer and mirror
// mode; memory contents are undefined until written. An output stall backs up
// the three stages before in_ch.ready falls.
//
module ppu_vram_scroll_address_unit
  import ppu_vsa_pkg::*;
#(
  parameter int unsigned MEMORY_DEPTH = 16384
) (
  input  logic                 clk,
  input  logic                 rst_n,
  ppu_vsa_in_if.sink           in_ch,
  ppu_vsa_out_if.source        out_ch,
  input  logic                 cfg_we,
  input  logic [2:0]           cfg_wdata
);

  localparam int unsigned AW = $clog2(MEMORY_DEPTH);

  logic          s1_v_r;
  in_item_t      s1_item_r;
  logic          s2_v_r;
  scroll_state_t s2_state_r;
  rd_sel_t       s2_sel_r;
  logic          out_v_r;
  logic [7:0]    out_rd_r;
  scroll_state_t out_state_r;
  logic [7:0]    rbuf_r;
  logic [2:0]    mirror_mode_r;

  logic          out_load;
  logic          s2_load;
  logic          in_fire;
  scroll_state_t state_r;
  scroll_state_t state_nxt;
  logic [VRAM_AW-1:0] raw_addr;
  logic [VRAM_AW-1:0] map_addr;
  logic          is_palette;
  logic          is_direct;
  logic          mem_we;
  logic          mem_re;
  logic [7:0]    mem_rdata;
  rd_sel_t       s1_sel;
  logic [7:0]    rd_val;

  // Pipeline flow control.
  assign out_load     = s2_v_r && (!out_v_r || out_ch.ready);
  assign s2_load      = s1_v_r && (!s2_v_r || out_load);
  assign in_ch.ready  = !s1_v_r || s2_load;
  assign in_fire      = in_ch.valid && in_ch.ready;

  // Mirror mode register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mirror_mode_r <= MIRROR_HORIZONTAL;
    end else if (cfg_we) begin
      mirror_mode_r <= cfg_wdata;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r.func            <= in_ch.func;
      s1_item_r.value           <= in_ch.value;
      s1_item_r.address         <= in_ch.address;
      s1_item_r.increment_by_32 <= in_ch.increment_by_32;
    end
  end

  // Scroll registers update as the transaction leaves the input register.
  ppu_vsa_scroll u_scroll (
    .clk       (clk),
    .rst_n     (rst_n),
    .upd       (s2_load),
    .item      (s1_item_r),
    .state_r   (state_r),
    .state_nxt (state_nxt)
  );

  // Memory address: direct operations use the given address, others the current one.
  assign is_direct = (s1_item_r.func == FUNC_DIRECT_READ) ||
                     (s1_item_r.func == FUNC_DIRECT_WRITE);
  assign raw_addr  = is_direct ? s1_item_r.address[VRAM_AW-1:0] : state_r.cur[VRAM_AW-1:0];

  ppu_vsa_addr_map u_map (
    .addr_in     (raw_addr),
    .mirror_mode (mirror_mode_r),
    .addr_out    (map_addr),
    .is_palette  (is_palette)
  );

  assign mem_we = s2_load && ((s1_item_r.func == FUNC_DATA_WRITE) ||
                              (s1_item_r.func == FUNC_DIRECT_WRITE));
  assign mem_re = s2_load && ((s1_item_r.func == FUNC_DATA_READ) ||
                              (s1_item_r.func == FUNC_DIRECT_READ));

  ppu_vsa_vram #(
    .MEMORY_DEPTH (MEMORY_DEPTH)
  ) u_vram (
    .clk     (clk),
    .we      (mem_we),
    .re      (mem_re),
    .addr    (map_addr[AW-1:0]),
    .wdata   (s1_item_r.value),
    .rdata_r (mem_rdata)
  );

  // Where the read data of this transaction comes from.
  always_comb begin
    case (s1_item_r.func)
      FUNC_DATA_READ:   s1_sel = is_palette ? RD_MEM : RD_BUF;
      FUNC_DIRECT_READ: s1_sel = RD_MEM;
      default:          s1_sel = RD_NONE;
    endcase
  end

  // Memory stage register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (!s2_v_r || out_load) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load) begin
      s2_state_r <= state_nxt;
      s2_sel_r   <= s1_sel;
    end
  end

  // Read data selection; buffered reads return the old buffer.
  always_comb begin
    case (s2_sel_r)
      RD_MEM:  rd_val = mem_rdata;
      RD_BUF:  rd_val = rbuf_r;
      default: rd_val = 8'd0;
    endcase
  end

  // Read buffer refills in transaction order.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rbuf_r <= 8'd0;
    end else if (out_load && s2_sel_r == RD_BUF) begin
      rbuf_r <= mem_rdata;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (!out_v_r || out_ch.ready) begin
      out_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_rd_r    <= rd_val;
      out_state_r <= s2_state_r;
    end
  end

  assign out_ch.valid           = out_v_r;
  assign out_ch.read_data       = out_rd_r;
  assign out_ch.current_address = out_state_r.cur;
  assign out_ch.temp_address    = out_state_r.tmp;
  assign out_ch.fine_x          = out_state_r.fine_x;
  assign out_ch.toggle          = out_state_r.toggle;

endmodule

FILE: hdl/ppu_vsa_addr_map.sv
// ============================================================================
// ppu_vsa_addr_map
// Mirrors a video address: 14-bit wrap, 0x3000 fold, palette fold, nametables.
// ============================================================================
module ppu_vsa_addr_map
  import ppu_vsa_pkg::*;
(
  input  logic [VRAM_AW-1:0] addr_in,
  input  logic [2:0]         mirror_mode,
  output logic [VRAM_AW-1:0] addr_out,
  output logic               is_palette
);

  logic [VRAM_AW-1:0] a;

  always_comb begin
    a = addr_in;
    // Fold 0x3000-0x3EFF down onto the nametables.
    if (a[13:12] == 2'b11 && a[11:8] != 4'hF) begin
      a[12] = 1'b0;
    end
    // Palette space repeats every 32 bytes.
    if (a[13:8] == 6'h3F) begin
      a[7:5] = 3'b000;
      // Sprite palette entry zero of each group aliases the background one.
      if (a[4] && a[1:0] == 2'b00) begin
        a[4] = 1'b0;
      end
    end
    // Nametable mirroring by mode.
    if (a[13:12] == 2'b10) begin
      case (mirror_mode)
        MIRROR_HORIZONTAL:  a[10] = 1'b0;
        MIRROR_VERTICAL:    a[11] = 1'b0;
        MIRROR_SINGLE_LOW:  a[11:10] = 2'b00;
        MIRROR_SINGLE_HIGH: a[11:10] = 2'b01;
        default: ;
      endcase
    end
    addr_out   = a;
    is_palette = (a[13:8] == 6'h3F);
  end

endmodule

FILE: hdl/ppu_vsa_scroll.sv
// ============================================================================
// ppu_vsa_scroll
// Current/temporary address, fine X and write toggle with their updates.
// ============================================================================
module ppu_vsa_scroll
  import ppu_vsa_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          upd,
  input  in_item_t      item,
  output scroll_state_t state_r,
  output scroll_state_t state_nxt
);

  logic [7:0]  val;
  logic [13:0] step_sum;
  logic [4:0]  cy;

  assign val = item.value;

  // Address step of 1 or 32, wrapped to 14 bits.
  assign step_sum = state_r.cur[13:0] + (item.increment_by_32 ? 14'd32 : 14'd1);

  // Next register state for the operation.
  always_comb begin
    state_nxt = state_r;
    cy        = state_r.cur[9:5];
    case (item.func)
      FUNC_CTRL: begin
        state_nxt.tmp[11:10] = val[1:0];
      end
      FUNC_SCROLL: begin
        if (state_r.toggle) begin
          state_nxt.tmp[14:12] = val[2:0];
          state_nxt.tmp[9:5]   = val[7:3];
        end else begin
          state_nxt.tmp[4:0] = val[7:3];
          state_nxt.fine_x   = val[2:0];
        end
        state_nxt.toggle = ~state_r.toggle;
      end
      FUNC_ADDR: begin
        if (state_r.toggle) begin
          state_nxt.tmp = {state_r.tmp[14:8], val};
          state_nxt.cur = {state_r.tmp[14:8], val};
        end else begin
          state_nxt.tmp = {1'b0, val[5:0], state_r.tmp[7:0]};
        end
        state_nxt.toggle = ~state_r.toggle;
      end
      FUNC_DATA_WRITE, FUNC_INCREMENT: begin
        state_nxt.cur = {1'b0, step_sum};
      end
      FUNC_CLEAR_TOGGLE: begin
        state_nxt.toggle = 1'b0;
      end
      FUNC_INC_X: begin
        if (state_r.cur[4:0] == 5'h1F) begin
          state_nxt.cur[4:0] = 5'd0;
          state_nxt.cur[10]  = ~state_r.cur[10];
        end else begin
          state_nxt.cur[4:0] = state_r.cur[4:0] + 5'd1;
        end
      end
      FUNC_INC_Y: begin
        if (state_r.cur[14:12] != 3'h7) begin
          state_nxt.cur[14:12] = state_r.cur[14:12] + 3'd1;
        end else begin
          state_nxt.cur[14:12] = 3'd0;
          if (state_r.cur[9:5] == COARSE_Y_LAST_ROW) begin
            cy                 = 5'd0;
            state_nxt.cur[11]  = ~state_r.cur[11];
          end else if (state_r.cur[9:5] == COARSE_Y_MAX) begin
            cy = 5'd0;
          end else begin
            cy = state_r.cur[9:5] + 5'd1;
          end
          state_nxt.cur[9:5] = cy;
        end
      end
      FUNC_COPY_X: begin
        state_nxt.cur[10]  = state_r.tmp[10];
        state_nxt.cur[4:0] = state_r.tmp[4:0];
      end
      FUNC_COPY_Y: begin
        state_nxt.cur[14:11] = state_r.tmp[14:11];
        state_nxt.cur[9:5]   = state_r.tmp[9:5];
      end
      default: ;
    endcase
  end

  // State registers advance once per transaction.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (upd) begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: hdl/ppu_vsa_vram.sv
// ============================================================================
// ppu_vsa_vram
// Single-port video memory with a registered read port.
// ============================================================================
module ppu_vsa_vram #(
  parameter int unsigned MEMORY_DEPTH = 16384
) (
  input  logic                            clk,
  input  logic                            we,
  input  logic                            re,
  input  logic [$clog2(MEMORY_DEPTH)-1:0] addr,
  input  logic [7:0]                      wdata,
  output logic [7:0]                      rdata_r
);

  logic [7:0] mem [MEMORY_DEPTH];

  // Write and registered read; read data holds until the next read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

endmodule

FILE: hdl/ppu_vsa_checker.sv
// ============================================================================
// ppu_vsa_checker
// Port-level assertions for the VRAM and scroll-address unit.
// ============================================================================
module ppu_vsa_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  out_read_data,
  input logic [14:0] out_current_address,
  input logic [14:0] out_temp_address
);

  logic [2:0] inflight_r;

  // Transactions accepted but not yet delivered.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inflight_r <= 3'd0;
    end else begin
      inflight_r <= inflight_r + {2'b00, in_valid && in_ready}
                                - {2'b00, out_valid && out_ready};
    end
  end

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid && in_ready)
    else $error("pipeline not empty after reset");

  // A result is only shown for an accepted transaction.
  a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> inflight_r != 3'd0)
    else $error("result without an accepted transaction");

  // The three stages bound the transactions in flight.
  a_depth: assert property (@(posedge clk) disable iff (!rst_n)
    inflight_r <= 3'd3)
    else $error("more transactions in flight than stages");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_read_data) &&
      $stable(out_current_address) && $stable(out_temp_address))
    else $error("stalled result changed");

endmodule

bind ppu_vram_scroll_address_unit ppu_vsa_checker u_ppu_vsa_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_valid            (in_ch.valid),
  .in_ready            (in_ch.ready),
  .out_valid           (out_ch.valid),
  .out_ready           (out_ch.ready),
  .out_read_data       (out_ch.read_data),
  .out_current_address (out_ch.current_address),
  .out_temp_address    (out_ch.temp_address)
);
